// ===== hdl/srtq_pkg.sv =====
// ----------------------------------------------------------------------------
// srtq_pkg: shared types and codes for the station result tracking queue
// Holds opcodes, status codes, counter selects, the command beat that moves
// from the front end to the back end, and the result beat.
// ----------------------------------------------------------------------------
package srtq_pkg;

    // Default sizes of the queue, the id range and the counters.
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int NUM_IDS_DEF     = 8;
    localparam int COUNT_WIDTH_DEF = 32;

    // Opcodes.
    localparam logic [2:0] OP_ADD_ENTRY = 3'd0;
    localparam logic [2:0] OP_NEW_PART  = 3'd1;
    localparam logic [2:0] OP_ADD_VALUE = 3'd2;
    localparam logic [2:0] OP_POP       = 3'd3;
    localparam logic [2:0] OP_CLEAR     = 3'd4;
    localparam logic [2:0] OP_SET_PART  = 3'd5;
    localparam logic [2:0] OP_READ_CNT  = 3'd6;

    // Status codes.
    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_EMPTY = 3'd1;
    localparam logic [2:0] ST_NOPOS = 3'd2;
    localparam logic [2:0] ST_DUP   = 3'd3;
    localparam logic [2:0] ST_FULL  = 3'd4;

    // Counter selects above the four evaluation rows.
    localparam logic [2:0] SEL_PARTS_IN = 3'd4;
    localparam logic [2:0] SEL_GOOD     = 3'd5;

    // Evaluation code of a passing measurement.
    localparam logic [1:0] EV_PASS = 2'd0;

    // Command beat after classification in the front end.
    typedef struct packed {
        logic [2:0]  op;
        logic [15:0] cycle_time;
        logic [2:0]  meas_id;
        logic [3:0]  back;
        logic [1:0]  eval;
        logic [31:0] meas_value;
        logic [15:0] meas_time;
        logic [31:0] part_number_in;
        logic [2:0]  counter_select;
    } cmd_t;

    // Result beat.
    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] part_number;
        logic [15:0] entry_cycle_time;
        logic [2:0]  out_id;
        logic [31:0] out_value;
        logic [15:0] out_time;
        logic [1:0]  out_eval;
        logic        has_value;
        logic        part_good;
        logic [31:0] newest_part_number;
        logic [31:0] counter_value;
        logic        last;
    } res_t;

endpackage

// ===== hdl/station_result_tracking_queue.sv =====
// ----------------------------------------------------------------------------
// station_result_tracking_queue: test station part tracking queue
// Accepted commands pass through the front end command queue to the back end,
// which registers each result beat. Add value, evaluation counter reads and
// pops first read their stores before the result beat is built, and a pop of
// an entry with measurements then emits one beat per measurement. The single
// back end sequencer and its registered stores take one command at a time.
// Reset clears the queue, the part number and all counters at once.
// ----------------------------------------------------------------------------
module station_result_tracking_queue
#(
    parameter int QUEUE_DEPTH = srtq_pkg::QUEUE_DEPTH_DEF,
    parameter int NUM_IDS     = srtq_pkg::NUM_IDS_DEF,
    parameter int COUNT_WIDTH = srtq_pkg::COUNT_WIDTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  opcode,
    input  logic [15:0] cycle_time,
    input  logic [2:0]  meas_id,
    input  logic [3:0]  station_offset,
    input  logic        is_dummy,
    input  logic [1:0]  eval_code,
    input  logic [31:0] meas_value,
    input  logic [15:0] meas_time,
    input  logic [31:0] part_number_in,
    input  logic [2:0]  counter_select,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [31:0] part_number,
    output logic [15:0] entry_cycle_time,
    output logic [2:0]  out_id,
    output logic [31:0] out_value,
    output logic [15:0] out_time,
    output logic [1:0]  out_eval,
    output logic        has_value,
    output logic        part_good,
    output logic [31:0] newest_part_number,
    output logic [31:0] counter_value,
    output logic        last
);

    logic           cmd_valid;
    logic           cmd_take;
    srtq_pkg::cmd_t cmd;
    srtq_pkg::res_t res;

    // Front end: accept and classify.
    srtq_front u_front
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .opcode         (opcode),
        .cycle_time     (cycle_time),
        .meas_id        (meas_id),
        .station_offset (station_offset),
        .is_dummy       (is_dummy),
        .eval_code      (eval_code),
        .meas_value     (meas_value),
        .meas_time      (meas_time),
        .part_number_in (part_number_in),
        .counter_select (counter_select),
        .cmd_valid      (cmd_valid),
        .cmd            (cmd),
        .cmd_take       (cmd_take)
    );

    // Back end: execute and emit result beats.
    srtq_back
    #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .NUM_IDS     (NUM_IDS),
        .COUNT_WIDTH (COUNT_WIDTH)
    )
    u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .res       (res)
    );

    // Result beat fields.
    assign status             = res.status;
    assign part_number        = res.part_number;
    assign entry_cycle_time   = res.entry_cycle_time;
    assign out_id             = res.out_id;
    assign out_value          = res.out_value;
    assign out_time           = res.out_time;
    assign out_eval           = res.out_eval;
    assign has_value          = res.has_value;
    assign part_good          = res.part_good;
    assign newest_part_number = res.newest_part_number;
    assign counter_value      = res.counter_value;
    assign last               = res.last;

endmodule

// ===== hdl/srtq_front.sv =====
// ----------------------------------------------------------------------------
// srtq_front: input side of the station result tracking queue
// Accepts input beats, resolves the target offset of a measurement and keeps
// the commands in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module srtq_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [2:0]          opcode,
    input  logic [15:0]         cycle_time,
    input  logic [2:0]          meas_id,
    input  logic [3:0]          station_offset,
    input  logic                is_dummy,
    input  logic [1:0]          eval_code,
    input  logic [31:0]         meas_value,
    input  logic [15:0]         meas_time,
    input  logic [31:0]         part_number_in,
    input  logic [2:0]          counter_select,
    output logic                cmd_valid,
    output srtq_pkg::cmd_t      cmd,
    input  logic                cmd_take
);

    srtq_pkg::cmd_t q_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     fill_reg;
    logic           push;
    srtq_pkg::cmd_t cmd_in;

    // Classify the beat: a dummy measurement targets the newest entry.
    always_comb
    begin
        cmd_in.op             = opcode;
        cmd_in.cycle_time     = cycle_time;
        cmd_in.meas_id        = meas_id;
        cmd_in.back           = is_dummy ? 4'd0 : station_offset;
        cmd_in.eval           = eval_code;
        cmd_in.meas_value     = meas_value;
        cmd_in.meas_time      = meas_time;
        cmd_in.part_number_in = part_number_in;
        cmd_in.counter_select = counter_select;
    end

    assign in_stall  = (fill_reg == 2'd2);
    assign push      = in_valid && !in_stall;
    assign cmd_valid = (fill_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];

    // Command queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    // Command queue pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (cmd_take)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            fill_reg <= fill_reg + 2'(push) - 2'(cmd_take);
        end
    end

`ifndef NO_ASSERTIONS
    // The back end never takes a command from an empty queue.
    a_take_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_take |-> cmd_valid)
        else $error("command taken from empty queue");

    // The fill level stays within the two entries.
    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg != 2'd3)
        else $error("command queue overfilled");

    // A push into a full queue cannot happen.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg == 2'd2 && !cmd_take) |=> fill_reg == 2'd2)
        else $error("command queue level lost");
`endif

endmodule

// ===== hdl/srtq_back.sv =====
// ----------------------------------------------------------------------------
// srtq_back: execution side of the station result tracking queue
// Owns the entry queue, the measurement stores and the counters, carries out
// one command at a time and drives the registered result beat.
// ----------------------------------------------------------------------------
module srtq_back
#(
    parameter int QUEUE_DEPTH = srtq_pkg::QUEUE_DEPTH_DEF,
    parameter int NUM_IDS     = srtq_pkg::NUM_IDS_DEF,
    parameter int COUNT_WIDTH = srtq_pkg::COUNT_WIDTH_DEF
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    input  srtq_pkg::cmd_t cmd,
    output logic           cmd_take,
    input  logic           out_stall,
    output logic           out_valid,
    output srtq_pkg::res_t res
);

    localparam int IDS    = (NUM_IDS < 8) ? NUM_IDS : 8;
    localparam int IDW    = (IDS > 1) ? $clog2(IDS) : 1;
    localparam int QW     = $clog2(QUEUE_DEPTH);
    localparam int CW     = QW + 1;
    localparam int MW     = 3 * IDS;
    localparam int VDEPTH = QUEUE_DEPTH << IDW;
    localparam int CDEPTH = 4 << IDW;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ADDV  = 3'd1;
    localparam logic [2:0] S_POP1  = 3'd2;
    localparam logic [2:0] S_POP2  = 3'd3;
    localparam logic [2:0] S_RDCNT = 3'd4;

    // Stores.
    logic [31:0]          part_mem [QUEUE_DEPTH];
    logic [15:0]          time_mem [QUEUE_DEPTH];
    logic [MW-1:0]        meta_mem [QUEUE_DEPTH];
    logic [47:0]          val_mem  [VDEPTH];
    logic [COUNT_WIDTH-1:0] cnt_mem [CDEPTH];

    // Read data.
    logic [31:0]            part_rd_reg;
    logic [15:0]            time_rd_reg;
    logic [MW-1:0]          meta_rd_reg;
    logic [47:0]            val_rd_reg;
    logic [COUNT_WIDTH-1:0] cnt_rd_reg;
    logic                   cnt_vld_rd_reg;

    // Control and state registers.
    logic [2:0]             state_reg, state_next;
    logic [QW-1:0]          head_reg, head_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [31:0]            newest_reg, newest_next;
    logic [31:0]            current_reg, current_next;
    logic [COUNT_WIDTH-1:0] parts_in_reg, parts_in_next;
    logic [COUNT_WIDTH-1:0] good_reg, good_next;
    logic [CDEPTH-1:0]      cnt_vld_reg, cnt_vld_next;
    logic                   out_valid_reg, out_valid_next;
    srtq_pkg::res_t         res_reg, res_next;
    srtq_pkg::cmd_t         cmd_reg, cmd_next;
    logic [QW-1:0]          slot_reg, slot_next;
    logic [31:0]            pop_part_reg, pop_part_next;
    logic [15:0]            pop_time_reg, pop_time_next;
    logic                   pop_good_reg, pop_good_next;
    logic [2*IDS-1:0]       pop_evals_reg, pop_evals_next;
    logic [IDS-1:0]         rem_reg, rem_next;
    logic [IDW-1:0]         cur_reg, cur_next;

    // Memory ports.
    logic                   part_we;
    logic                   meta_we, meta_re;
    logic [QW-1:0]          meta_wa, meta_ra;
    logic [MW-1:0]          meta_wd;
    logic                   val_we, val_re;
    logic [QW+IDW-1:0]      val_wa, val_ra;
    logic                   cnt_re, cnt_we;
    logic [IDW+1:0]         cnt_ra, cnt_wa;
    logic [COUNT_WIDTH-1:0] cnt_wd;
    logic                   pop_re;

    // Address arithmetic.
    logic [CW:0]            tail_sum, tgt_sum;
    logic [QW-1:0]          tail_slot, tgt_slot;
    logic [CW+3:0]          back_ext, newest_pos;
    logic                   pos_ok, id_ok;
    logic [IDW-1:0]         cmd_id;

    // Helpers.
    logic                   can_emit;
    logic [IDS-1:0]         mpresent;
    logic [2*IDS-1:0]       mevals;
    logic                   all_pass;
    logic [IDW-1:0]         first_id, next_id;
    logic [IDS-1:0]         rem_after;
    logic [COUNT_WIDTH+31:0] cnt_ext, parts_ext, good_ext;
    logic [COUNT_WIDTH-1:0] cnt_cur;

    assign cmd_id    = cmd.meas_id[IDW-1:0];
    assign id_ok     = (5'(cmd.meas_id) < 5'(IDS));
    assign can_emit  = !out_valid_reg || !out_stall;
    assign mpresent  = meta_rd_reg[IDS-1:0];
    assign mevals    = meta_rd_reg[MW-1:IDS];

    // Slot of the next free entry and of the measurement target.
    always_comb
    begin
        tail_sum   = (CW+1)'(head_reg) + (CW+1)'(count_reg);
        tail_slot  = (tail_sum >= (CW+1)'(QUEUE_DEPTH)) ?
                     QW'(tail_sum - (CW+1)'(QUEUE_DEPTH)) : QW'(tail_sum);
        back_ext   = (CW+4)'(cmd.back);
        newest_pos = (CW+4)'(count_reg) - (CW+4)'(1);
        pos_ok     = (back_ext <= newest_pos);
        tgt_sum    = (CW+1)'(head_reg) + (CW+1)'(newest_pos - back_ext);
        tgt_slot   = (tgt_sum >= (CW+1)'(QUEUE_DEPTH)) ?
                     QW'(tgt_sum - (CW+1)'(QUEUE_DEPTH)) : QW'(tgt_sum);
    end

    // Good check and first present id of the popped entry.
    always_comb
    begin
        all_pass = 1'b1;
        first_id = '0;
        for (int i = IDS - 1; i >= 0; i--)
        begin
            if (mpresent[i] && mevals[2*i +: 2] != srtq_pkg::EV_PASS)
            begin
                all_pass = 1'b0;
            end
            if (mpresent[i])
            begin
                first_id = IDW'(i);
            end
        end
    end

    // Next id still to be emitted after the current one.
    always_comb
    begin
        rem_after = rem_reg;
        rem_after[cur_reg] = 1'b0;
        next_id = '0;
        for (int i = IDS - 1; i >= 0; i--)
        begin
            if (rem_after[i])
            begin
                next_id = IDW'(i);
            end
        end
    end

    // Low 32 bits of the counters.
    always_comb
    begin
        cnt_cur   = cnt_vld_rd_reg ? cnt_rd_reg : '0;
        cnt_ext   = {32'd0, cnt_cur};
        parts_ext = {32'd0, parts_in_reg};
        good_ext  = {32'd0, good_reg};
    end

    // Command sequencer.
    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        newest_next    = newest_reg;
        current_next   = current_reg;
        parts_in_next  = parts_in_reg;
        good_next      = good_reg;
        cnt_vld_next   = cnt_vld_reg;
        cmd_next       = cmd_reg;
        slot_next      = slot_reg;
        pop_part_next  = pop_part_reg;
        pop_time_next  = pop_time_reg;
        pop_good_next  = pop_good_reg;
        pop_evals_next = pop_evals_reg;
        rem_next       = rem_reg;
        cur_next       = cur_reg;
        cmd_take       = 1'b0;
        part_we        = 1'b0;
        meta_we        = 1'b0;
        meta_re        = 1'b0;
        meta_wa        = tail_slot;
        meta_ra        = head_reg;
        meta_wd        = '0;
        val_we         = 1'b0;
        val_re         = 1'b0;
        val_wa         = {slot_reg, cmd_reg.meas_id[IDW-1:0]};
        val_ra         = {slot_reg, cur_reg};
        cnt_re         = 1'b0;
        cnt_we         = 1'b0;
        cnt_ra         = {cmd.eval, cmd_id};
        cnt_wa         = {cmd_reg.eval, cmd_reg.meas_id[IDW-1:0]};
        cnt_wd         = cnt_cur + COUNT_WIDTH'(1);
        pop_re         = 1'b0;
        out_valid_next = out_valid_reg && out_stall;
        res_next       = res_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && can_emit)
                begin
                    cmd_take = 1'b1;
                    cmd_next = cmd;
                    out_valid_next = 1'b1;
                    res_next = '0;
                    res_next.status = srtq_pkg::ST_OK;
                    res_next.last = 1'b1;
                    case (cmd.op)
                        srtq_pkg::OP_ADD_ENTRY:
                        begin
                            if (count_reg >= CW'(QUEUE_DEPTH))
                            begin
                                res_next.status = srtq_pkg::ST_FULL;
                            end
                            else
                            begin
                                part_we     = 1'b1;
                                meta_we     = 1'b1;
                                count_next  = count_reg + CW'(1);
                                newest_next = current_reg;
                            end
                        end
                        srtq_pkg::OP_NEW_PART:
                        begin
                            parts_in_next = parts_in_reg + COUNT_WIDTH'(1);
                            current_next  = current_reg + 32'd1;
                        end
                        srtq_pkg::OP_ADD_VALUE:
                        begin
                            if (count_reg == '0)
                            begin
                                res_next.status = srtq_pkg::ST_EMPTY;
                            end
                            else if (!pos_ok || !id_ok)
                            begin
                                res_next.status = srtq_pkg::ST_NOPOS;
                            end
                            else
                            begin
                                out_valid_next = out_valid_reg && out_stall;
                                res_next   = res_reg;
                                slot_next  = tgt_slot;
                                meta_re    = 1'b1;
                                meta_ra    = tgt_slot;
                                cnt_re     = 1'b1;
                                state_next = S_ADDV;
                            end
                        end
                        srtq_pkg::OP_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                res_next.status = srtq_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                out_valid_next = out_valid_reg && out_stall;
                                res_next   = res_reg;
                                slot_next  = head_reg;
                                meta_re    = 1'b1;
                                pop_re     = 1'b1;
                                state_next = S_POP1;
                            end
                        end
                        srtq_pkg::OP_CLEAR:
                        begin
                            count_next  = '0;
                            head_next   = '0;
                            newest_next = 32'd0;
                        end
                        srtq_pkg::OP_SET_PART:
                        begin
                            current_next = cmd.part_number_in;
                        end
                        srtq_pkg::OP_READ_CNT:
                        begin
                            if (cmd.counter_select < srtq_pkg::SEL_PARTS_IN)
                            begin
                                if (id_ok)
                                begin
                                    out_valid_next = out_valid_reg && out_stall;
                                    res_next   = res_reg;
                                    cnt_re     = 1'b1;
                                    cnt_ra     = {cmd.counter_select[1:0], cmd_id};
                                    state_next = S_RDCNT;
                                end
                            end
                            else if (cmd.counter_select == srtq_pkg::SEL_PARTS_IN)
                            begin
                                res_next.counter_value = parts_ext[31:0];
                            end
                            else if (cmd.counter_select == srtq_pkg::SEL_GOOD)
                            begin
                                res_next.counter_value = good_ext[31:0];
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    res_next.newest_part_number = newest_next;
                end
            end
            S_ADDV:
            begin
                if (can_emit)
                begin
                    out_valid_next = 1'b1;
                    res_next = '0;
                    res_next.last = 1'b1;
                    res_next.newest_part_number = newest_reg;
                    if (mpresent[cmd_reg.meas_id[IDW-1:0]])
                    begin
                        res_next.status = srtq_pkg::ST_DUP;
                    end
                    else
                    begin
                        res_next.status = srtq_pkg::ST_OK;
                        val_we  = 1'b1;
                        meta_we = 1'b1;
                        meta_wa = slot_reg;
                        meta_wd = meta_rd_reg;
                        meta_wd[cmd_reg.meas_id[IDW-1:0]] = 1'b1;
                        meta_wd[IDS + 2*cmd_reg.meas_id[IDW-1:0] +: 2] = cmd_reg.eval;
                        cnt_we  = 1'b1;
                        cnt_vld_next[cnt_wa] = 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end
            S_POP1:
            begin
                if (can_emit)
                begin
                    pop_part_next  = part_rd_reg;
                    pop_time_next  = time_rd_reg;
                    pop_good_next  = all_pass;
                    pop_evals_next = mevals;
                    if (all_pass)
                    begin
                        good_next = good_reg + COUNT_WIDTH'(1);
                    end
                    head_next  = (head_reg == QW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + QW'(1);
                    count_next = count_reg - CW'(1);
                    if (count_reg == CW'(1))
                    begin
                        newest_next = 32'd0;
                    end
                    if (mpresent == '0)
                    begin
                        out_valid_next = 1'b1;
                        res_next = '0;
                        res_next.status = srtq_pkg::ST_OK;
                        res_next.part_number = part_rd_reg;
                        res_next.entry_cycle_time = time_rd_reg;
                        res_next.part_good = all_pass;
                        res_next.newest_part_number = newest_next;
                        res_next.last = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        rem_next   = mpresent;
                        cur_next   = first_id;
                        val_re     = 1'b1;
                        val_ra     = {slot_reg, first_id};
                        state_next = S_POP2;
                    end
                end
            end
            S_POP2:
            begin
                if (can_emit)
                begin
                    out_valid_next = 1'b1;
                    res_next = '0;
                    res_next.status = srtq_pkg::ST_OK;
                    res_next.part_number = pop_part_reg;
                    res_next.entry_cycle_time = pop_time_reg;
                    res_next.out_id = 3'(cur_reg);
                    res_next.out_value = val_rd_reg[31:0];
                    res_next.out_time = val_rd_reg[47:32];
                    res_next.out_eval = pop_evals_reg[2*cur_reg +: 2];
                    res_next.has_value = 1'b1;
                    res_next.part_good = pop_good_reg;
                    res_next.newest_part_number = newest_reg;
                    res_next.last = (rem_after == '0);
                    rem_next = rem_after;
                    if (rem_after == '0)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cur_next = next_id;
                        val_re   = 1'b1;
                        val_ra   = {slot_reg, next_id};
                    end
                end
            end
            S_RDCNT:
            begin
                if (can_emit)
                begin
                    out_valid_next = 1'b1;
                    res_next = '0;
                    res_next.status = srtq_pkg::ST_OK;
                    res_next.counter_value = cnt_ext[31:0];
                    res_next.newest_part_number = newest_reg;
                    res_next.last = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Entry stores.
    always_ff @(posedge clk)
    begin
        if (part_we)
        begin
            part_mem[tail_slot] <= current_reg;
            time_mem[tail_slot] <= cmd.cycle_time;
        end
        if (pop_re)
        begin
            part_rd_reg <= part_mem[head_reg];
            time_rd_reg <= time_mem[head_reg];
        end
    end

    // Presence and evaluation store.
    always_ff @(posedge clk)
    begin
        if (meta_we)
        begin
            meta_mem[meta_wa] <= meta_wd;
        end
        if (meta_re)
        begin
            meta_rd_reg <= meta_mem[meta_ra];
        end
    end

    // Value and duration store.
    always_ff @(posedge clk)
    begin
        if (val_we)
        begin
            val_mem[val_wa] <= {cmd_reg.meas_time, cmd_reg.meas_value};
        end
        if (val_re)
        begin
            val_rd_reg <= val_mem[val_ra];
        end
    end

    // Evaluation counter store.
    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[cnt_wa] <= cnt_wd;
        end
        if (cnt_re)
        begin
            cnt_rd_reg     <= cnt_mem[cnt_ra];
            cnt_vld_rd_reg <= cnt_vld_reg[cnt_ra];
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        res_reg       <= res_next;
        cmd_reg       <= cmd_next;
        slot_reg      <= slot_next;
        pop_part_reg  <= pop_part_next;
        pop_time_reg  <= pop_time_next;
        pop_good_reg  <= pop_good_next;
        pop_evals_reg <= pop_evals_next;
        cur_reg       <= cur_next;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            newest_reg    <= 32'd0;
            current_reg   <= 32'd0;
            parts_in_reg  <= '0;
            good_reg      <= '0;
            cnt_vld_reg   <= '0;
            out_valid_reg <= 1'b0;
            rem_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            newest_reg    <= newest_next;
            current_reg   <= current_next;
            parts_in_reg  <= parts_in_next;
            good_reg      <= good_next;
            cnt_vld_reg   <= cnt_vld_next;
            out_valid_reg <= out_valid_next;
            rem_reg       <= rem_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign res       = res_reg;

`ifndef NO_ASSERTIONS
    // The entry count never passes the queue depth.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("entry count beyond depth");

    // An empty queue reports no newest part.
    a_empty_newest: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == '0 |-> newest_reg == 32'd0)
        else $error("newest part set on empty queue");

    // While emitting measurements some id is still pending.
    a_pop_pending: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_POP2 |-> rem_reg != '0)
        else $error("pop emission without pending id");

    // A result carrying a measurement always has status ok.
    a_value_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.has_value) |-> res_reg.status == srtq_pkg::ST_OK)
        else $error("measurement result with error status");

    // Commands are taken only in the idle state.
    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_take |-> state_reg == S_IDLE)
        else $error("command taken while busy");
`endif

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for the station result tracking queue
// Drives directed and random commands, predicts the result beats with a local
// model of the queue and the counters, and checks every output beat in order.
// ----------------------------------------------------------------------------
module tb;

    localparam int DEPTH = 16;
    localparam int IDS   = 8;

    // Opcode without a function; the block answers it with a plain ok beat.
    localparam logic [2:0] OP_NONE = 3'd7;

    typedef struct packed {
        logic [2:0]  op;
        logic [15:0] ctime;
        logic [2:0]  id;
        logic [3:0]  offs;
        logic        dummy;
        logic [1:0]  ev;
        logic [31:0] val;
        logic [15:0] mtime;
        logic [31:0] pnum;
        logic [2:0]  sel;
    } cmd_beat_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic out_valid;
    logic out_stall;
    cmd_beat_t drv;
    srtq_pkg::res_t got;

    station_result_tracking_queue u_dut
    (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .opcode(drv.op), .cycle_time(drv.ctime), .meas_id(drv.id),
        .station_offset(drv.offs), .is_dummy(drv.dummy), .eval_code(drv.ev),
        .meas_value(drv.val), .meas_time(drv.mtime),
        .part_number_in(drv.pnum), .counter_select(drv.sel),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(got.status), .part_number(got.part_number),
        .entry_cycle_time(got.entry_cycle_time), .out_id(got.out_id),
        .out_value(got.out_value), .out_time(got.out_time),
        .out_eval(got.out_eval), .has_value(got.has_value),
        .part_good(got.part_good), .newest_part_number(got.newest_part_number),
        .counter_value(got.counter_value), .last(got.last)
    );

    // Local copy of the queue state.
    logic [31:0] q_part [DEPTH];
    logic [15:0] q_time [DEPTH];
    logic [7:0]  q_present [DEPTH];
    logic [1:0]  q_eval [DEPTH][IDS];
    logic [31:0] q_val [DEPTH][IDS];
    logic [15:0] q_dur [DEPTH][IDS];
    int          q_head;
    int          q_count;
    logic [31:0] cur_part;
    logic [31:0] parts_in;
    logic [31:0] good_total;
    logic [31:0] eval_cnt [4][IDS];

    cmd_beat_t      pending_cmds[$];
    srtq_pkg::res_t expected_beats[$];
    int             errors;
    int             hold_long;
    int             total_cmds;
    int             sent_cmds;
    bit             in_took;

    task automatic report(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        errors++;
    endtask

    task automatic expect_beat(input srtq_pkg::res_t r);
        expected_beats = {expected_beats, r};
    endtask

    task automatic queue_cmd(input cmd_beat_t c);
        pending_cmds = {pending_cmds, c};
        total_cmds++;
    endtask

    function automatic srtq_pkg::res_t basic_beat(input logic [2:0] st);
        srtq_pkg::res_t r;
        r = '0;
        r.status = st;
        r.newest_part_number = (q_count == 0) ? 32'd0
                               : q_part[(q_head + q_count - 1) % DEPTH];
        r.last = 1'b1;
        return r;
    endfunction

    // Applies one command to the local state and queues its result beats.
    task automatic predict_queue_step(input cmd_beat_t c);
        int s;
        int back;
        int n;
        bit good;
        srtq_pkg::res_t r;
        srtq_pkg::res_t beats[$];
        logic [31:0] part;
        logic [15:0] tm;
        case (c.op)
            srtq_pkg::OP_ADD_ENTRY:
            begin
                if (q_count >= DEPTH)
                    expect_beat(basic_beat(srtq_pkg::ST_FULL));
                else
                begin
                    s = (q_head + q_count) % DEPTH;
                    q_part[s] = cur_part;
                    q_time[s] = c.ctime;
                    q_present[s] = '0;
                    q_count++;
                    expect_beat(basic_beat(srtq_pkg::ST_OK));
                end
            end
            srtq_pkg::OP_NEW_PART:
            begin
                parts_in++;
                cur_part++;
                expect_beat(basic_beat(srtq_pkg::ST_OK));
            end
            srtq_pkg::OP_ADD_VALUE:
            begin
                back = c.dummy ? 0 : int'(c.offs);
                if (q_count == 0)
                    expect_beat(basic_beat(srtq_pkg::ST_EMPTY));
                else if (back > q_count - 1)
                    expect_beat(basic_beat(srtq_pkg::ST_NOPOS));
                else
                begin
                    s = (q_head + q_count - 1 - back) % DEPTH;
                    if (q_present[s][c.id])
                        expect_beat(basic_beat(srtq_pkg::ST_DUP));
                    else
                    begin
                        q_val[s][c.id] = c.val;
                        q_dur[s][c.id] = c.mtime;
                        q_eval[s][c.id] = c.ev;
                        q_present[s][c.id] = 1'b1;
                        eval_cnt[c.ev][c.id]++;
                        expect_beat(basic_beat(srtq_pkg::ST_OK));
                    end
                end
            end
            srtq_pkg::OP_POP:
            begin
                if (q_count == 0)
                    expect_beat(basic_beat(srtq_pkg::ST_EMPTY));
                else
                begin
                    s = q_head;
                    good = 1'b1;
                    for (int i = 0; i < IDS; i++)
                        if (q_present[s][i] && q_eval[s][i] != srtq_pkg::EV_PASS)
                            good = 1'b0;
                    if (good)
                        good_total++;
                    part = q_part[s];
                    tm = q_time[s];
                    q_head = (s + 1) % DEPTH;
                    q_count--;
                    for (int i = 0; i < IDS; i++)
                        if (q_present[s][i])
                        begin
                            r = basic_beat(srtq_pkg::ST_OK);
                            r.out_id = 3'(i);
                            r.out_value = q_val[s][i];
                            r.out_time = q_dur[s][i];
                            r.out_eval = q_eval[s][i];
                            r.has_value = 1'b1;
                            beats = {beats, r};
                        end
                    if (beats.size() == 0)
                        beats = {beats, basic_beat(srtq_pkg::ST_OK)};
                    n = beats.size();
                    for (int i = 0; i < n; i++)
                    begin
                        r = beats[i];
                        r.part_number = part;
                        r.entry_cycle_time = tm;
                        r.part_good = good;
                        r.last = (i == n - 1);
                        expect_beat(r);
                    end
                end
            end
            srtq_pkg::OP_CLEAR:
            begin
                q_count = 0;
                q_head = 0;
                expect_beat(basic_beat(srtq_pkg::ST_OK));
            end
            srtq_pkg::OP_SET_PART:
            begin
                cur_part = c.pnum;
                expect_beat(basic_beat(srtq_pkg::ST_OK));
            end
            srtq_pkg::OP_READ_CNT:
            begin
                r = basic_beat(srtq_pkg::ST_OK);
                if (c.sel < srtq_pkg::SEL_PARTS_IN)
                    r.counter_value = eval_cnt[c.sel[1:0]][c.id];
                else if (c.sel == srtq_pkg::SEL_PARTS_IN)
                    r.counter_value = parts_in;
                else if (c.sel == srtq_pkg::SEL_GOOD)
                    r.counter_value = good_total;
                expect_beat(r);
            end
            default:
                expect_beat(basic_beat(srtq_pkg::ST_OK));
        endcase
    endtask

    function automatic cmd_beat_t rand_cmd(input logic [2:0] op);
        cmd_beat_t c;
        c.op = op;
        c.ctime = 16'($urandom);
        c.id = 3'($urandom);
        c.offs = 4'($urandom);
        c.dummy = 1'($urandom);
        c.ev = ($urandom_range(0, 2) == 0) ? 2'($urandom) : srtq_pkg::EV_PASS;
        c.val = $urandom;
        c.mtime = 16'($urandom);
        c.pnum = $urandom;
        c.sel = 3'($urandom);
        return c;
    endfunction

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Input acceptance: sampled at the rising edge and fed to the predictor.
    initial in_took = 1'b0;
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            predict_queue_step(drv);
            sent_cmds++;
            in_took = 1'b1;
        end
    end

    // Driver: offers the pending commands with random gaps.
    int in_gap;
    initial in_gap = 0;
    always @(negedge clk)
    begin
        if (in_took)
        begin
            in_took = 1'b0;
            in_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
            if (pending_cmds.size() > 0 && in_gap == 0)
            begin
                drv <= pending_cmds[0];
                pending_cmds.delete(0);
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
        else if (rst_n && !in_valid)
        begin
            if (in_gap > 0)
                in_gap--;
            else if (pending_cmds.size() > 0)
            begin
                drv <= pending_cmds[0];
                pending_cmds.delete(0);
                in_valid <= 1'b1;
            end
        end
    end

    // Receiver stall: random waits per beat, plus one long hold-off.
    int out_gap;
    initial out_gap = 0;
    always @(negedge clk)
    begin
        if (hold_long > 0)
        begin
            hold_long--;
            out_stall <= 1'b1;
        end
        else if (out_gap > 0)
        begin
            out_gap--;
            out_stall <= 1'b1;
        end
        else if (out_valid && !out_stall)
        begin
            out_gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 16);
            out_stall <= (out_gap != 0);
        end
        else
            out_stall <= 1'b0;
    end

    // Monitor: checks each accepted result beat against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_beats.size() == 0)
                report("result beat with nothing expected");
            else
            begin
                srtq_pkg::res_t e;
                e = expected_beats[0];
                expected_beats.delete(0);
                if (got.status !== e.status) report("status");
                if (got.part_number !== e.part_number) report("part_number");
                if (got.entry_cycle_time !== e.entry_cycle_time)
                    report("entry_cycle_time");
                if (got.out_id !== e.out_id) report("out_id");
                if (got.out_value !== e.out_value) report("out_value");
                if (got.out_time !== e.out_time) report("out_time");
                if (got.out_eval !== e.out_eval) report("out_eval");
                if (got.has_value !== e.has_value) report("has_value");
                if (got.part_good !== e.part_good) report("part_good");
                if (got.newest_part_number !== e.newest_part_number)
                    report("newest_part_number");
                if (got.counter_value !== e.counter_value) report("counter_value");
                if (got.last !== e.last) report("last");
            end
        end
    end

    // Stimulus.
    initial
    begin
        cmd_beat_t c;
        int k;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        drv = '0;
        errors = 0;
        hold_long = 0;
        total_cmds = 0;
        sent_cmds = 0;
        q_head = 0;
        q_count = 0;
        cur_part = '0;
        parts_in = '0;
        good_total = '0;
        for (int i = 0; i < DEPTH; i++) q_present[i] = '0;
        for (int e = 0; e < 4; e++)
            for (int i = 0; i < IDS; i++) eval_cnt[e][i] = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty cases, extremes, duplicate, offsets, full queue.
        queue_cmd(rand_cmd(srtq_pkg::OP_POP));
        c = rand_cmd(srtq_pkg::OP_ADD_VALUE);
        queue_cmd(c);
        c = rand_cmd(srtq_pkg::OP_SET_PART); c.pnum = '1; queue_cmd(c);
        queue_cmd(rand_cmd(srtq_pkg::OP_NEW_PART));
        c = rand_cmd(srtq_pkg::OP_ADD_ENTRY); c.ctime = '1; queue_cmd(c);
        c = rand_cmd(srtq_pkg::OP_ADD_VALUE); c.dummy = 1; c.id = 7; c.ev = 3;
        c.val = '1; c.mtime = '1; queue_cmd(c);
        queue_cmd(c);
        c.dummy = 0; c.offs = 15; queue_cmd(c);
        c.offs = 0; c.id = 0; c.val = 0; c.mtime = 0; c.ev = 0;
        queue_cmd(c);
        queue_cmd(rand_cmd(srtq_pkg::OP_POP));
        c = rand_cmd(srtq_pkg::OP_ADD_ENTRY); c.ctime = 0; queue_cmd(c);
        queue_cmd(rand_cmd(srtq_pkg::OP_POP));
        for (k = 0; k < 17; k++) queue_cmd(rand_cmd(srtq_pkg::OP_ADD_ENTRY));
        c = rand_cmd(srtq_pkg::OP_ADD_VALUE); c.dummy = 0; c.offs = 15; c.id = 3;
        queue_cmd(c);
        for (k = 0; k < 8; k++)
        begin
            c = rand_cmd(srtq_pkg::OP_READ_CNT); c.sel = 3'(k); queue_cmd(c);
        end
        queue_cmd(rand_cmd(OP_NONE));
        queue_cmd(rand_cmd(srtq_pkg::OP_CLEAR));

        // Random: mostly well-formed part flows with random content.
        for (k = 0; k < 160; k++)
        begin
            case ($urandom_range(0, 19))
                0, 1, 2:      c = rand_cmd(srtq_pkg::OP_ADD_ENTRY);
                3:            c = rand_cmd(srtq_pkg::OP_NEW_PART);
                4, 5, 6, 7, 8, 9, 10:
                begin
                    c = rand_cmd(srtq_pkg::OP_ADD_VALUE);
                    if ($urandom_range(0, 3) != 0)
                        c.offs = 4'($urandom_range(0, 3));
                end
                11, 12, 13:   c = rand_cmd(srtq_pkg::OP_POP);
                14:           c = rand_cmd($urandom_range(0, 9) == 0 ?
                                           srtq_pkg::OP_CLEAR : OP_NONE);
                15:           c = rand_cmd(srtq_pkg::OP_SET_PART);
                default:      c = rand_cmd(srtq_pkg::OP_READ_CNT);
            endcase
            queue_cmd(c);
            if (k == 80)
                hold_long = 300;
        end

        wait (sent_cmds == total_cmds);
        wait (expected_beats.size() == 0);
        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Timeout.
    initial
    begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end
endmodule

// ===== filelist.f =====
hdl/srtq_pkg.sv
hdl/srtq_front.sv
hdl/srtq_back.sv
hdl/station_result_tracking_queue.sv
tb/tb.sv
